@@ rtl/sdspi_pkg.sv @@
// Package for the SPI-mode SD card host sequencer.
// Shared constants, types and helpers; no dependencies.
package sdspi_pkg;

    localparam int BlockBytes  = 512;
    localparam int PacketBytes = BlockBytes + 2;

    // operation codes of an input word
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_BYTE = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    // command codes (bit 7 marks an application command)
    localparam logic [7:0] C_GO_IDLE  = 8'h40;
    localparam logic [7:0] C_OP_MMC   = 8'h41;
    localparam logic [7:0] C_IF_COND  = 8'h48;
    localparam logic [7:0] C_BLOCKLEN = 8'h50;
    localparam logic [7:0] C_READ1    = 8'h51;
    localparam logic [7:0] C_APP      = 8'h77;
    localparam logic [7:0] C_READ_OCR = 8'h7A;
    localparam logic [7:0] C_APP_OP   = 8'hE9;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RDERR  = 2'd1;
    localparam logic [1:0] ST_NOINIT = 2'd2;

    // card kinds
    localparam logic [2:0] K_NONE  = 3'd0;
    localparam logic [2:0] K_MMC   = 3'd1;
    localparam logic [2:0] K_SDV1  = 3'd2;
    localparam logic [2:0] K_SDV2  = 3'd3;
    localparam logic [2:0] K_SDV2B = 3'd4;

    // configuration register indexes
    localparam logic [2:0] R_DUMMY  = 3'd0;
    localparam logic [2:0] R_SETTLE = 3'd1;
    localparam logic [2:0] R_RETRY  = 3'd2;
    localparam logic [2:0] R_RESP   = 3'd3;
    localparam logic [2:0] R_TOKEN  = 3'd4;
    localparam logic [2:0] R_READY  = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  rx;
        logic [31:0] sector;
        logic [8:0]  offset;
        logic [9:0]  count;
    } t_in;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       fast_clock;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_kind;
    } t_out;

    typedef struct packed {
        logic [7:0]  dummy;
        logic [15:0] settle;
        logic [15:0] retry;
        logic [7:0]  resp;
        logic [15:0] token;
        logic [15:0] ready;
    } t_cfg;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

@@ rtl/sdspi_cfg.sv @@
// Configuration register file of the SD SPI sequencer.
// Depends on sdspi_pkg.
module sdspi_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output sdspi_pkg::t_cfg      o_cfg
);
    sdspi_pkg::t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dummy  <= 8'd50;
            r_cfg.settle <= 16'd250;
            r_cfg.retry  <= 16'd25000;
            r_cfg.resp   <= 8'd10;
            r_cfg.token  <= 16'd1000;
            r_cfg.ready  <= 16'd5000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdspi_pkg::R_DUMMY:  r_cfg.dummy  <= i_cfg_data[7:0];
                sdspi_pkg::R_SETTLE: r_cfg.settle <= i_cfg_data;
                sdspi_pkg::R_RETRY:  r_cfg.retry  <= i_cfg_data;
                sdspi_pkg::R_RESP:   r_cfg.resp   <= i_cfg_data[7:0];
                sdspi_pkg::R_TOKEN:  r_cfg.token  <= i_cfg_data;
                sdspi_pkg::R_READY:  r_cfg.ready  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

@@ rtl/sdspi_seq.sv @@
// Sequencer core: one step per input word, result into an output register.
// Depends on sdspi_pkg.
module sdspi_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  sdspi_pkg::t_in   i_item,
    input  sdspi_pkg::t_cfg  i_cfg,
    output sdspi_pkg::t_out  o_res
);
    typedef enum logic [3:0] {
        PH_IDLE, PH_DUMMY, PH_SETTLE, PH_CMD0, PH_CMD8, PH_R7, PH_HCS,
        PH_CMD58, PH_OCR, PH_PROBE, PH_WAIT, PH_CMD16, PH_CMD17,
        PH_TOKEN, PH_DATA
    } t_phase;

    typedef enum logic [2:0] {
        S_RDY55, S_TX55, S_RSP55, S_RDY, S_TX, S_RSP
    } t_stage;

    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [2:0]  r_kind, n_kind, r_pend, n_pend;
    logic [15:0] r_retry, n_retry, r_poll, n_poll;
    logic [9:0]  r_bcnt, n_bcnt;
    logic [31:0] r_ocr, n_ocr;
    logic [47:0] r_frame, n_frame;
    logic [18:0] r_win, n_win;
    logic        r_var, n_var, r_cs, n_cs, r_fast, n_fast;
    sdspi_pkg::t_out r_res, n_res;

    // scratch of the step logic
    logic [7:0]  rx, crc, code, rsp;
    logic [31:0] arg, addr;
    logic        start, fin_i, fin_r, do_rsp, busy, r7ok;
    logic [1:0]  rd_st;
    logic [47:0] fsel;
    logic [2:0]  fidx;
    logic [10:0] wend;
    logic [15:0] pdec;

    always_comb begin
        n_phase = r_phase; n_stage = r_stage; n_kind = r_kind; n_pend = r_pend;
        n_retry = r_retry; n_poll = r_poll; n_bcnt = r_bcnt; n_ocr = r_ocr;
        n_frame = r_frame; n_win = r_win; n_var = r_var; n_cs = r_cs;
        n_fast = r_fast;
        n_res = '0;
        n_res.tx_byte = 8'hFF;
        rx = i_item.rx;
        start = 1'b0; code = '0; arg = '0; busy = 1'b0;
        fin_i = 1'b0; fin_r = 1'b0; rd_st = sdspi_pkg::ST_OK;
        do_rsp = 1'b0; rsp = 8'hFF; crc = 8'h01; addr = '0; r7ok = 1'b0;
        fidx = '0; fsel = r_frame;
        wend = {2'b0, r_win[8:0]} + {1'b0, r_win[18:9]};
        pdec = r_poll - 16'd1;

        case (i_item.op)
            sdspi_pkg::OP_INIT: begin
                n_phase = PH_DUMMY; n_cs = 1'b0; n_fast = 1'b0;
                n_kind = sdspi_pkg::K_NONE; n_pend = sdspi_pkg::K_NONE;
                n_bcnt = {2'b0, i_cfg.dummy};
                if (i_cfg.dummy != 8'd0) n_res.tx_valid = 1'b1;
                else begin
                    n_cs = 1'b1; n_poll = i_cfg.settle;
                    if (i_cfg.settle == 16'd0) begin
                        n_phase = PH_CMD0; start = 1'b1; code = sdspi_pkg::C_GO_IDLE;
                    end else n_phase = PH_SETTLE;
                end
            end
            sdspi_pkg::OP_READ: begin
                if (r_phase == PH_IDLE) begin
                    if (r_kind == sdspi_pkg::K_NONE) begin
                        fin_r = 1'b1; rd_st = sdspi_pkg::ST_NOINIT;
                    end else begin
                        addr = (r_kind == sdspi_pkg::K_SDV2B) ? i_item.sector
                                                              : {i_item.sector[22:0], 9'd0};
                        n_win = {i_item.count, i_item.offset};
                        n_cs = 1'b1; n_phase = PH_CMD17;
                        start = 1'b1; code = sdspi_pkg::C_READ1; arg = addr;
                    end
                end
            end
            sdspi_pkg::OP_TICK: begin
                if (r_phase == PH_SETTLE) begin
                    n_poll = pdec;
                    if (pdec == 16'd0) begin
                        n_phase = PH_CMD0; start = 1'b1; code = sdspi_pkg::C_GO_IDLE;
                    end
                end
            end
            default: begin
                case (r_phase)
                    PH_DUMMY: begin
                        n_bcnt = r_bcnt - 10'd1;
                        if (r_bcnt != 10'd1) n_res.tx_valid = 1'b1;
                        else begin
                            n_cs = 1'b1; n_poll = i_cfg.settle;
                            if (i_cfg.settle == 16'd0) begin
                                n_phase = PH_CMD0; start = 1'b1;
                                code = sdspi_pkg::C_GO_IDLE;
                            end else n_phase = PH_SETTLE;
                        end
                    end
                    PH_R7, PH_OCR: begin
                        n_ocr = {r_ocr[23:0], rx};
                        n_bcnt = r_bcnt + 10'd1;
                        if (r_bcnt < 10'd3) n_res.tx_valid = 1'b1;
                        else if (r_phase == PH_OCR) begin
                            n_pend = n_ocr[30] ? sdspi_pkg::K_SDV2B : sdspi_pkg::K_SDV2;
                            fin_i = 1'b1;
                        end else begin
                            r7ok = (n_ocr[15:8] == 8'h01) && (n_ocr[7:0] == 8'hAA);
                            if (r7ok) begin
                                n_phase = PH_HCS;
                                n_retry = sdspi_pkg::at_least_one(i_cfg.retry);
                                start = 1'b1; code = sdspi_pkg::C_APP_OP;
                                arg = 32'h4000_0000; n_var = 1'b1;
                            end else begin
                                n_pend = sdspi_pkg::K_NONE; fin_i = 1'b1;
                            end
                        end
                    end
                    PH_TOKEN: begin
                        if (rx == 8'hFF) begin
                            n_poll = pdec;
                            if (pdec != 16'd0) n_res.tx_valid = 1'b1;
                            else begin fin_r = 1'b1; rd_st = sdspi_pkg::ST_RDERR; end
                        end else if (rx == 8'hFE) begin
                            n_phase = PH_DATA; n_bcnt = '0; n_res.tx_valid = 1'b1;
                        end else begin
                            fin_r = 1'b1; rd_st = sdspi_pkg::ST_RDERR;
                        end
                    end
                    PH_DATA: begin
                        if ({1'b0, r_bcnt} >= {2'b0, r_win[8:0]} &&
                            {1'b0, r_bcnt} < wend) begin
                            n_res.data_valid = 1'b1; n_res.data_byte = rx;
                        end
                        n_bcnt = r_bcnt + 10'd1;
                        if (n_bcnt >= 10'(sdspi_pkg::PacketBytes)) fin_r = 1'b1;
                        else n_res.tx_valid = 1'b1;
                    end
                    PH_IDLE, PH_SETTLE: ;
                    default: begin
                        // command engine
                        if (r_stage == S_RDY55 || r_stage == S_RDY) begin
                            if (rx == 8'hFF) begin
                                n_stage = t_stage'(r_stage + 3'd1); n_bcnt = '0;
                                fidx = 3'd0; n_res.tx_valid = 1'b1;
                            end else begin
                                n_poll = pdec;
                                if (pdec != 16'd0) n_res.tx_valid = 1'b1;
                                else begin do_rsp = 1'b1; rsp = 8'hFF; end
                            end
                        end else if (r_stage == S_TX55 || r_stage == S_TX) begin
                            n_bcnt = r_bcnt + 10'd1;
                            if (n_bcnt < 10'd6) begin
                                fidx = n_bcnt[2:0]; n_res.tx_valid = 1'b1;
                            end else begin
                                n_stage = t_stage'(r_stage + 3'd1);
                                n_poll = {8'd0, (i_cfg.resp == 8'd0) ? 8'd1 : i_cfg.resp};
                                n_res.tx_valid = 1'b1;
                            end
                        end else begin
                            busy = r_var ? (rx == 8'hFF) : rx[7];
                            if (busy) n_poll = pdec;
                            if (busy && pdec != 16'd0) n_res.tx_valid = 1'b1;
                            else if (r_stage == S_RSP || (!r_var && rx > 8'd1)) begin
                                do_rsp = 1'b1; rsp = rx;
                            end else begin
                                n_stage = S_RDY;
                                n_poll = sdspi_pkg::at_least_one(i_cfg.ready);
                                n_res.tx_valid = 1'b1;
                            end
                        end
                        if (r_stage <= S_RSP55)
                            fsel = {sdspi_pkg::C_APP, 32'd0, r_var ? 8'hFF : 8'h01};
                        // frame bytes go out once the card is ready, and while sending
                        if (n_res.tx_valid &&
                            (((r_stage == S_RDY55 || r_stage == S_RDY) && rx == 8'hFF) ||
                             ((r_stage == S_TX55 || r_stage == S_TX) && n_bcnt < 10'd6)))
                            n_res.tx_byte = fsel[8*(5-fidx) +: 8];
                    end
                endcase

                // command result handling
                if (do_rsp) begin
                    case (r_phase)
                        PH_CMD0: begin
                            if (rsp == 8'd1) begin
                                n_phase = PH_CMD8; start = 1'b1;
                                code = sdspi_pkg::C_IF_COND; arg = 32'h1AA;
                            end else begin n_pend = sdspi_pkg::K_NONE; fin_i = 1'b1; end
                        end
                        PH_CMD8: begin
                            if (rsp == 8'd1) begin
                                n_phase = PH_R7; n_bcnt = '0; n_ocr = '0;
                                n_res.tx_valid = 1'b1;
                            end else begin
                                n_phase = PH_PROBE; start = 1'b1;
                                code = sdspi_pkg::C_APP_OP;
                            end
                        end
                        PH_HCS: begin
                            if (rsp == 8'd0) begin
                                n_phase = PH_CMD58; start = 1'b1;
                                code = sdspi_pkg::C_READ_OCR;
                            end else begin
                                n_retry = r_retry - 16'd1;
                                if (n_retry == 16'd0) begin
                                    n_pend = sdspi_pkg::K_NONE; fin_i = 1'b1;
                                end else begin
                                    start = 1'b1; code = sdspi_pkg::C_APP_OP;
                                    arg = 32'h4000_0000; n_var = 1'b1;
                                end
                            end
                        end
                        PH_CMD58: begin
                            if (rsp == 8'd0) begin
                                n_phase = PH_OCR; n_bcnt = '0; n_ocr = '0;
                                n_res.tx_valid = 1'b1;
                            end else begin n_pend = sdspi_pkg::K_NONE; fin_i = 1'b1; end
                        end
                        PH_PROBE: begin
                            n_pend = (rsp <= 8'd1) ? sdspi_pkg::K_SDV1 : sdspi_pkg::K_MMC;
                            n_phase = PH_WAIT;
                            n_retry = sdspi_pkg::at_least_one(i_cfg.retry);
                            start = 1'b1;
                            code = (rsp <= 8'd1) ? sdspi_pkg::C_APP_OP : sdspi_pkg::C_OP_MMC;
                        end
                        PH_WAIT: begin
                            if (rsp == 8'd0) begin
                                n_phase = PH_CMD16; start = 1'b1;
                                code = sdspi_pkg::C_BLOCKLEN;
                                arg = 32'(sdspi_pkg::BlockBytes);
                            end else begin
                                n_retry = r_retry - 16'd1;
                                if (n_retry == 16'd0) begin
                                    n_pend = sdspi_pkg::K_NONE; fin_i = 1'b1;
                                end else begin
                                    start = 1'b1;
                                    code = (r_pend == sdspi_pkg::K_SDV1) ?
                                           sdspi_pkg::C_APP_OP : sdspi_pkg::C_OP_MMC;
                                end
                            end
                        end
                        PH_CMD16: begin
                            if (rsp != 8'd0) n_pend = sdspi_pkg::K_NONE;
                            fin_i = 1'b1;
                        end
                        PH_CMD17: begin
                            if (rsp == 8'd0) begin
                                n_phase = PH_TOKEN;
                                n_poll = sdspi_pkg::at_least_one(i_cfg.token);
                                n_res.tx_valid = 1'b1;
                            end else begin fin_r = 1'b1; rd_st = sdspi_pkg::ST_RDERR; end
                        end
                        default: ;
                    endcase
                end
            end
        endcase

        // build and launch a command frame
        if (start) begin
            if (code[6:0] == sdspi_pkg::C_GO_IDLE[6:0]) crc = 8'h95;
            else if (code[6:0] == sdspi_pkg::C_IF_COND[6:0]) crc = 8'h87;
            if (n_var && arg == 32'h4000_0000 && code == sdspi_pkg::C_APP_OP
                && (r_phase == PH_R7 || r_phase == PH_HCS)) crc = 8'hFF;
            else n_var = 1'b0;
            n_frame = {1'b0, code[6:0], arg, crc};
            n_stage = code[7] ? S_RDY55 : S_RDY;
            n_poll = sdspi_pkg::at_least_one(i_cfg.ready);
            n_res.tx_valid = 1'b1; n_res.tx_byte = 8'hFF;
        end
        if (fin_i) begin
            n_kind = n_pend; n_phase = PH_IDLE; n_cs = 1'b0; n_fast = 1'b1;
            n_res.done_res = 1'b1;
            n_res.status = (n_pend != sdspi_pkg::K_NONE) ? sdspi_pkg::ST_OK
                                                         : sdspi_pkg::ST_NOINIT;
        end
        if (fin_r) begin
            n_phase = PH_IDLE; n_cs = 1'b0; n_res.done_res = 1'b1; n_res.status = rd_st;
        end
        n_res.chip_select = n_cs;
        n_res.fast_clock = n_fast;
        n_res.card_kind = n_kind;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_stage <= S_RDY55; r_kind <= '0; r_pend <= '0;
            r_retry <= '0; r_poll <= '0; r_bcnt <= '0; r_ocr <= '0;
            r_frame <= '0; r_win <= '0; r_var <= 1'b0; r_cs <= 1'b0;
            r_fast <= 1'b0; r_res <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_stage <= n_stage; r_kind <= n_kind;
            r_pend <= n_pend; r_retry <= n_retry; r_poll <= n_poll;
            r_bcnt <= n_bcnt; r_ocr <= n_ocr; r_frame <= n_frame;
            r_win <= n_win; r_var <= n_var; r_cs <= n_cs; r_fast <= n_fast;
            r_res <= n_res;
        end
    end

    assign o_res = r_res;
endmodule

@@ rtl/sd_card_spi_init_and_read.sv @@
// Top level of the SPI-mode SD/MMC host sequencer.
// Depends on sdspi_pkg, sdspi_cfg and sdspi_seq.
//
// channel   dir  tdata (low bit first)                        tuser
// s_axis    in   rx_byte[7:0] sector[39:8] offset[48:40]       operation
//                count[58:49], zero to 64
// m_axis    out  tx_valid tx_byte chip_select fast_clock       -
//                data_valid data_byte done_res status card_kind, zero to 32
// cfg       in   index 0..5, 16-bit write data
//
// One word per cycle unless m_axis stalls; each word's step is one pass from the state
// registers to the result register, seen in the cycle after the word is taken.
// Synchronous active-low reset returns to idle with no card. m_axis stalls hold the
// result register; s_axis_tready is high whenever it is empty or being taken.
module sd_card_spi_init_and_read (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // rx_byte, sector, offset, count
    input  logic [1:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tx_valid,tx_byte,cs,fast,dv,db,done,status,kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    sdspi_pkg::t_cfg cfg;
    sdspi_pkg::t_in  item;
    sdspi_pkg::t_out res;
    logic            r_full;
    logic            step;

    assign s_axis_tready = !r_full || m_axis_tready;
    assign step = s_axis_tvalid && s_axis_tready;

    assign item.op     = s_axis_tuser;
    assign item.rx     = s_axis_tdata[7:0];
    assign item.sector = s_axis_tdata[39:8];
    assign item.offset = s_axis_tdata[48:40];
    assign item.count  = s_axis_tdata[58:49];

    sdspi_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    sdspi_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step),
        .i_item(item), .i_cfg(cfg), .o_res(res)
    );

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (step) r_full <= 1'b1;
        else if (m_axis_tready) r_full <= 1'b0;
    end

    assign m_axis_tvalid = r_full;
    assign m_axis_tdata = {6'd0, res.card_kind, res.status, res.done_res, res.data_byte,
                           res.data_valid, res.fast_clock, res.chip_select,
                           res.tx_byte, res.tx_valid};

    // status is only reported with done
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.done_res |-> res.status == sdspi_pkg::ST_OK)
        else $error("status set without done");
    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // block bytes come only from an initialized card
    a_data_card: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.data_valid |-> res.card_kind != sdspi_pkg::K_NONE)
        else $error("data delivered without a card");
endmodule

@@ verif/tb_sd_card_spi_init_and_read.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the SPI-mode SD card host sequencer.
// Needs sdspi_pkg and sd_card_spi_init_and_read; a built-in card responder drives the stream.
module tb_sd_card_spi_init_and_read;

    localparam int StuckLimit = 4000;

    typedef enum logic [3:0] {
        S_IDLE, S_DUMMY, S_SETTLE, S_CMD0, S_CMD8, S_R7, S_HCS, S_CMD58,
        S_OCR, S_PROBE, S_WAIT, S_CMD16, S_CMD17, S_TOKEN, S_DATA
    } t_seq;

    typedef enum logic [2:0] {G_RDY55, G_TX55, G_RSP55, G_RDY, G_TX, G_RSP} t_frame;

    typedef struct {
        sdspi_pkg::t_in w;
        bit             typed;
        logic [31:0]    want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // rx_byte, sector, offset, count
    logic [1:0]  s_axis_tuser = sdspi_pkg::OP_TICK; // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // tx_valid,tx_byte,cs,fast,dv,db,done,status,kind
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = sdspi_pkg::R_DUMMY;
    logic [15:0] i_cfg_data = '0;

    sd_card_spi_init_and_read dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- sequencer predictor ----------------
    logic [7:0]  c_dummy, c_resp;
    logic [15:0] c_settle, c_retry, c_token, c_ready;

    t_seq        p_phase;
    t_frame      p_stage;
    logic [2:0]  p_kind, p_pend;
    logic [15:0] p_retry;
    int unsigned p_bytes, p_poll;
    logic [31:0] p_ocr, p_addr;
    logic [19:0] p_window;
    logic [47:0] p_frame;
    bit          p_pre, p_alt, p_cs, p_fast;

    bit          o_txv, o_dv, o_done;
    logic [7:0]  o_txb, o_db;
    logic [1:0]  o_stat;

    logic [31:0] result_q[$];
    int          n_bad = 0;
    int          burst_left = 0;

    function automatic void model_reset();
        c_dummy = 8'd50; c_settle = 16'd250; c_retry = 16'd25000;
        c_resp = 8'd10; c_token = 16'd1000; c_ready = 16'd5000;
        p_phase = S_IDLE; p_stage = G_RDY55; p_kind = sdspi_pkg::K_NONE;
        p_pend = sdspi_pkg::K_NONE;
        p_retry = '0; p_bytes = 0; p_poll = 0; p_ocr = '0; p_addr = '0;
        p_window = '0; p_frame = '0; p_pre = 0; p_alt = 0; p_cs = 0; p_fast = 0;
    endfunction

    function automatic logic [15:0] nz(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [31:0] mk(input bit txv, input logic [7:0] txb, input bit cs,
                                       input bit fast, input bit dv, input logic [7:0] db,
                                       input bit done, input logic [1:0] stat,
                                       input logic [2:0] kind);
        return {6'd0, kind, stat, done, db, dv, fast, cs, txb, txv};
    endfunction

    function automatic void put_tx(input logic [7:0] b);
        o_txv = 1; o_txb = b;
    endfunction

    function automatic logic [7:0] frame_byte(input int unsigned k);
        logic [47:0] f;
        f = p_frame;
        if (p_stage <= G_RSP55) f = {sdspi_pkg::C_APP, 32'd0, p_alt ? 8'hFF : 8'h01};
        return f[(47 - 8 * k) -: 8];
    endfunction

    function automatic void start_cmd(input logic [7:0] code, input logic [31:0] arg,
                                      input bit alt);
        logic [7:0] idx, crc;
        idx = {1'b0, code[6:0]};
        crc = 8'h01;
        if (idx == sdspi_pkg::C_GO_IDLE) crc = 8'h95;
        if (idx == sdspi_pkg::C_IF_COND) crc = 8'h87;
        if (alt) crc = 8'hFF;
        p_alt = alt;
        p_pre = code[7];
        p_frame = {idx, arg, crc};
        p_stage = p_pre ? G_RDY55 : G_RDY;
        p_poll = 32'(nz(c_ready));
        put_tx(8'hFF);
    endfunction

    function automatic void finish_init();
        p_kind = p_pend; p_phase = S_IDLE; p_cs = 0; p_fast = 1; o_done = 1;
        o_stat = (p_pend != sdspi_pkg::K_NONE) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_NOINIT;
    endfunction

    function automatic void finish_read(input logic [1:0] st);
        p_phase = S_IDLE; p_cs = 0; o_done = 1; o_stat = st;
    endfunction

    function automatic void fail_init();
        p_pend = sdspi_pkg::K_NONE;
        finish_init();
    endfunction

    function automatic void retry_or_fail(input logic [7:0] code, input logic [31:0] arg,
                                          input bit alt);
        p_retry = p_retry - 16'd1;
        if (p_retry == 0) fail_init();
        else start_cmd(code, arg, alt);
    endfunction

    // command response handling per init/read step
    function automatic void cmd_result(input logic [7:0] r);
        case (p_phase)
            S_CMD0: if (r == 8'h01) begin
                p_phase = S_CMD8; start_cmd(sdspi_pkg::C_IF_COND, 32'h1AA, 0);
            end else fail_init();
            S_CMD8: if (r == 8'h01) begin
                p_phase = S_R7; p_bytes = 0; p_ocr = '0; put_tx(8'hFF);
            end else begin
                p_phase = S_PROBE; start_cmd(sdspi_pkg::C_APP_OP, 32'd0, 0);
            end
            S_HCS: if (r == 8'h00) begin
                p_phase = S_CMD58; start_cmd(sdspi_pkg::C_READ_OCR, 32'd0, 0);
            end else retry_or_fail(sdspi_pkg::C_APP_OP, 32'h4000_0000, 1);
            S_CMD58: if (r == 8'h00) begin
                p_phase = S_OCR; p_bytes = 0; p_ocr = '0; put_tx(8'hFF);
            end else fail_init();
            S_PROBE: begin
                p_pend = (r <= 8'h01) ? sdspi_pkg::K_SDV1 : sdspi_pkg::K_MMC;
                p_phase = S_WAIT;
                p_retry = nz(c_retry);
                start_cmd((p_pend == sdspi_pkg::K_SDV1) ? sdspi_pkg::C_APP_OP
                                                        : sdspi_pkg::C_OP_MMC, 32'd0, 0);
            end
            S_WAIT: if (r == 8'h00) begin
                p_phase = S_CMD16;
                start_cmd(sdspi_pkg::C_BLOCKLEN, 32'(sdspi_pkg::BlockBytes), 0);
            end else retry_or_fail((p_pend == sdspi_pkg::K_SDV1) ? sdspi_pkg::C_APP_OP
                                                                 : sdspi_pkg::C_OP_MMC,
                                   32'd0, 0);
            S_CMD16: begin
                if (r != 8'h00) p_pend = sdspi_pkg::K_NONE;
                finish_init();
            end
            S_CMD17: if (r == 8'h00) begin
                p_phase = S_TOKEN; p_poll = 32'(nz(c_token)); put_tx(8'hFF);
            end else finish_read(sdspi_pkg::ST_RDERR);
            default: ;
        endcase
    endfunction

    // ready poll, frame send and response poll of one command
    function automatic void engine_rx(input logic [7:0] rx);
        bit busy;
        case (p_stage)
            G_RDY55, G_RDY: begin
                if (rx == 8'hFF) begin
                    p_stage = t_frame'(p_stage + 1);
                    p_bytes = 0;
                    put_tx(frame_byte(0));
                end else begin
                    p_poll = p_poll - 1;
                    if (p_poll != 0) put_tx(8'hFF);
                    else cmd_result(8'hFF);
                end
            end
            G_TX55, G_TX: begin
                p_bytes = p_bytes + 1;
                if (p_bytes < 6) put_tx(frame_byte(p_bytes));
                else begin
                    p_stage = t_frame'(p_stage + 1);
                    p_poll = 32'(nz({8'd0, c_resp}));
                    put_tx(8'hFF);
                end
            end
            default: begin
                busy = p_alt ? (rx == 8'hFF) : rx[7];
                if (busy) p_poll = p_poll - 1;
                if (busy && p_poll != 0) put_tx(8'hFF);
                else if (p_stage == G_RSP) cmd_result(rx);
                else if (!p_alt && rx > 8'h01) cmd_result(rx);
                else begin
                    p_stage = G_RDY; p_poll = 32'(nz(c_ready)); put_tx(8'hFF);
                end
            end
        endcase
    endfunction

    function automatic void enter_settle();
        p_cs = 1;
        p_poll = 32'(c_settle);
        if (p_poll == 0) begin
            p_phase = S_CMD0; start_cmd(sdspi_pkg::C_GO_IDLE, 32'd0, 0);
        end else p_phase = S_SETTLE;
    endfunction

    function automatic void byte_rx(input logic [7:0] rx);
        int unsigned off, cnt;
        case (p_phase)
            S_DUMMY: begin
                p_bytes = p_bytes - 1;
                if (p_bytes != 0) put_tx(8'hFF);
                else enter_settle();
            end
            S_R7, S_OCR: begin
                p_ocr = {p_ocr[23:0], rx};
                p_bytes = p_bytes + 1;
                if (p_bytes < 4) put_tx(8'hFF);
                else if (p_phase == S_OCR) begin
                    p_pend = p_ocr[30] ? sdspi_pkg::K_SDV2B : sdspi_pkg::K_SDV2;
                    finish_init();
                end else if (p_ocr[15:8] == 8'h01 && p_ocr[7:0] == 8'hAA) begin
                    p_phase = S_HCS;
                    p_retry = nz(c_retry);
                    start_cmd(sdspi_pkg::C_APP_OP, 32'h4000_0000, 1);
                end else fail_init();
            end
            S_TOKEN: begin
                if (rx == 8'hFF) begin
                    p_poll = p_poll - 1;
                    if (p_poll != 0) put_tx(8'hFF);
                    else finish_read(sdspi_pkg::ST_RDERR);
                end else if (rx == 8'hFE) begin
                    p_phase = S_DATA; p_bytes = 0; put_tx(8'hFF);
                end else finish_read(sdspi_pkg::ST_RDERR);
            end
            S_DATA: begin
                off = 32'(p_window[8:0]);
                cnt = 32'(p_window[18:9]);
                if (p_bytes >= off && p_bytes < off + cnt) begin
                    o_dv = 1; o_db = rx;
                end
                p_bytes = p_bytes + 1;
                if (p_bytes >= sdspi_pkg::PacketBytes) finish_read(sdspi_pkg::ST_OK);
                else put_tx(8'hFF);
            end
            S_IDLE, S_SETTLE: ;
            default: engine_rx(rx);
        endcase
    endfunction

    // one input word in, the expected result word out
    function automatic logic [31:0] seq_step(input sdspi_pkg::t_in w);
        o_txv = 0; o_dv = 0; o_done = 0; o_txb = 8'hFF; o_db = 8'h00;
        o_stat = sdspi_pkg::ST_OK;
        case (w.op)
            sdspi_pkg::OP_INIT: begin
                p_phase = S_DUMMY; p_cs = 0; p_fast = 0; p_kind = sdspi_pkg::K_NONE;
                p_pend = sdspi_pkg::K_NONE;
                p_bytes = 32'(c_dummy);
                if (p_bytes != 0) put_tx(8'hFF);
                else enter_settle();
            end
            sdspi_pkg::OP_READ: if (p_phase == S_IDLE) begin
                if (p_kind == sdspi_pkg::K_NONE) finish_read(sdspi_pkg::ST_NOINIT);
                else begin
                    p_addr = (p_kind == sdspi_pkg::K_SDV2B) ? w.sector
                                                            : {w.sector[22:0], 9'd0};
                    p_window = {1'b0, w.count, w.offset};
                    p_cs = 1;
                    p_phase = S_CMD17;
                    start_cmd(sdspi_pkg::C_READ1, p_addr, 0);
                end
            end
            sdspi_pkg::OP_BYTE: byte_rx(w.rx);
            default: if (p_phase == S_SETTLE) begin
                p_poll = p_poll - 1;
                if (p_poll == 0) begin
                    p_phase = S_CMD0; start_cmd(sdspi_pkg::C_GO_IDLE, 32'd0, 0);
                end
            end
        endcase
        return mk(o_txv, o_txb, p_cs, p_fast, o_dv, o_db, o_done, o_stat, p_kind);
    endfunction

    // ---------------- card responder ----------------
    // Mostly answers what a well-behaved card would, with busy bytes, bad replies and noise.
    function automatic sdspi_pkg::t_in next_word(input bit allow_init);
        sdspi_pkg::t_in w;
        w.op = sdspi_pkg::OP_BYTE;
        w.rx = 8'hFF;
        w.sector = $urandom;
        w.offset = 9'($urandom_range(0, 511));
        w.count = 10'($urandom_range(0, 512));
        if ($urandom_range(0, 19) == 0) begin
            w.op = ($urandom_range(0, 2) == 0) ? sdspi_pkg::OP_READ :
                   (($urandom_range(0, 1) == 0) ? sdspi_pkg::OP_TICK : sdspi_pkg::OP_BYTE);
            w.rx = 8'($urandom);
            return w;
        end
        if (allow_init && $urandom_range(0, 299) == 0) begin
            w.op = sdspi_pkg::OP_INIT;
            return w;
        end
        case (p_phase)
            S_IDLE: begin
                if (allow_init && (p_kind == sdspi_pkg::K_NONE || $urandom_range(0, 5) == 0))
                    w.op = sdspi_pkg::OP_INIT;
                else w.op = sdspi_pkg::OP_READ;
                case ($urandom_range(0, 3))
                    0: begin w.offset = 9'd511; w.count = 10'd512; end
                    1: begin w.offset = 9'd0; w.count = 10'($urandom_range(0, 4)); end
                    2: w.count = 10'($urandom_range(0, 16));
                    default: ;
                endcase
                if ($urandom_range(0, 5) == 0) w.sector = 32'hFFFF_FFFF;
            end
            S_SETTLE: w.op = sdspi_pkg::OP_TICK;
            S_DUMMY, S_OCR, S_DATA: w.rx = 8'($urandom);
            S_R7: begin
                case (p_bytes)
                    2: w.rx = 8'h01;
                    3: w.rx = 8'hAA;
                    default: w.rx = 8'h00;
                endcase
                if ($urandom_range(0, 5) == 0) w.rx = 8'($urandom);
            end
            S_TOKEN: begin
                if ($urandom_range(0, 2) == 0) w.rx = 8'hFE;
                else if ($urandom_range(0, 7) == 0) w.rx = 8'($urandom);
            end
            default: case (p_stage)
                G_RDY55, G_RDY: if ($urandom_range(0, 3) == 0) w.rx = 8'($urandom);
                G_TX55, G_TX: w.rx = 8'($urandom);
                G_RSP55: begin
                    if (p_alt) w.rx = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'h01;
                    else if ($urandom_range(0, 3) == 0) w.rx = 8'h80 | 8'($urandom);
                    else w.rx = ($urandom_range(0, 7) == 0) ? 8'h05 : 8'h01;
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) w.rx = 8'h80 | 8'($urandom);
                    else case (p_phase)
                        S_CMD0: w.rx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h01;
                        S_CMD8, S_PROBE:
                            w.rx = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'h05;
                        S_HCS, S_WAIT:
                            w.rx = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
                        default:
                            w.rx = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
                    endcase
                end
            endcase
        endcase
        return w;
    endfunction

    // ---------------- stimulus side ----------------
    task automatic put_word(input sdspi_pkg::t_in w, input bit typed, input logic [31:0] want);
        logic [31:0] e;
        if (burst_left == 0) begin
            if (s_axis_tvalid) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, w.count, w.offset, w.sector, w.rx};
        s_axis_tuser <= w.op;
        do @(posedge i_clk); while (!s_axis_tready);
        e = seq_step(w);
        result_q.push_back(typed ? want : e);
    endtask

    // hold off until every expected word has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 16'(v);
        case (idx)
            sdspi_pkg::R_DUMMY:  c_dummy = 8'(v);
            sdspi_pkg::R_SETTLE: c_settle = 16'(v);
            sdspi_pkg::R_RETRY:  c_retry = 16'(v);
            sdspi_pkg::R_RESP:   c_resp = 8'(v);
            sdspi_pkg::R_TOKEN:  c_token = 16'(v);
            default:             c_ready = 16'(v);
        endcase
    endtask

    task automatic set_regs(input int d, input int s, input int r, input int rs,
                            input int t, input int rd);
        write_reg(sdspi_pkg::R_DUMMY, d);
        write_reg(sdspi_pkg::R_SETTLE, s);
        write_reg(sdspi_pkg::R_RETRY, r);
        write_reg(sdspi_pkg::R_RESP, rs);
        write_reg(sdspi_pkg::R_TOKEN, t);
        write_reg(sdspi_pkg::R_READY, rd);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n, input bit allow_init, input int pause_at);
        for (int i = 0; i < n; i++) begin
            if (i == pause_at) drain();
            put_word(next_word(allow_init), 0, '0);
        end
    endtask

    // ---------------- receiver stall pattern ----------------
    initial begin
        int run_left;
        bit steady;
        run_left = 0;
        steady = 1;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                steady = 1'($urandom_range(0, 1));
                run_left = $urandom_range(10, 80);
            end
            run_left--;
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 2) == 0);
        end
    end

    function automatic logic [7:0] fld(input logic [31:0] w, input int f);
        case (f)
            0: return {7'd0, w[0]};
            1: return w[8:1];
            2: return {7'd0, w[9]};
            3: return {7'd0, w[10]};
            4: return {7'd0, w[11]};
            5: return w[19:12];
            6: return {7'd0, w[20]};
            7: return {6'd0, w[22:21]};
            8: return {5'd0, w[25:23]};
            default: return {2'd0, w[31:26]};
        endcase
    endfunction

    function automatic string fld_name(input int f);
        case (f)
            0: return "tx_valid";
            1: return "tx_byte";
            2: return "chip_select";
            3: return "fast_clock";
            4: return "data_valid";
            5: return "data_byte";
            6: return "done_res";
            7: return "status";
            8: return "card_kind";
            default: return "pad";
        endcase
    endfunction

    // ---------------- result check and watchdog ----------------
    int stuck = 0;
    always @(posedge i_clk) begin
        logic [31:0] e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                n_bad++;
                $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
            end else begin
                e = result_q.pop_front();
                for (int f = 0; f < 10; f++) begin
                    if (fld(e, f) !== fld(m_axis_tdata, f)) begin
                        n_bad++;
                        $display("%0t: %s expected %h actual %h", $time, fld_name(f),
                                 fld(e, f), fld(m_axis_tdata, f));
                    end
                end
            end
        end
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= StuckLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_dir_row dir_rows[$];
        sdspi_pkg::t_in w;
        model_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_regs(1, 2, 2, 2, 2, 2);

        // directed words: no-card reads, ignored words, a failing CMD0, a CMD0 frame
        w = '{sdspi_pkg::OP_READ, 8'h00, 32'hFFFF_FFFF, 9'd511, 10'd512};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 0, 0, 0, 0, 1, sdspi_pkg::ST_NOINIT,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_READ, 8'hFF, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 0, 0, 0, 0, 1, sdspi_pkg::ST_NOINIT,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_TICK, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 0, 0, 0, 0, 0, sdspi_pkg::ST_OK,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_BYTE, 8'hFF, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 0, 0, 0, 0, 0, sdspi_pkg::ST_OK,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_INIT, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 1, mk(1, 8'hFF, 0, 0, 0, 0, 0, sdspi_pkg::ST_OK,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_BYTE, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 1, 0, 0, 0, 0, sdspi_pkg::ST_OK,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_READ, 8'h00, 32'h1234_5678, 9'd3, 10'd7};
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 1, 0, 0, 0, 0, sdspi_pkg::ST_OK,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_TICK, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_BYTE, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        dir_rows.push_back('{w, 1, mk(0, 8'hFF, 0, 1, 0, 0, 1, sdspi_pkg::ST_NOINIT,
                                      sdspi_pkg::K_NONE)});
        w = '{sdspi_pkg::OP_READ, 8'h00, 32'h0, 9'd0, 10'd512};
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_INIT, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_BYTE, 8'hAA, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_TICK, 8'h00, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_BYTE, 8'hFF, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_BYTE, 8'h55, 32'h0, 9'd0, 10'd0};
        repeat (6) dir_rows.push_back('{w, 0, '0});
        w = '{sdspi_pkg::OP_BYTE, 8'hFF, 32'h0, 9'd0, 10'd0};
        dir_rows.push_back('{w, 0, '0});
        dir_rows.push_back('{w, 0, '0});
        foreach (dir_rows[i]) put_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // random runs over several register settings
        set_regs(3, 2, 3, 2, 4, 2);
        run_random(450, 1, 200);
        drain();
        set_regs(0, 0, 0, 0, 0, 0);
        run_random(300, 1, -1);
        drain();
        set_regs(255, 0, 65535, 255, 65535, 65535);
        run_random(400, 1, -1);
        drain();
        set_regs(5, 65535, 3, 3, 3, 3);
        run_random(150, 0, -1);
        drain();
        set_regs($urandom_range(0, 8), $urandom_range(1, 4), $urandom_range(1, 6),
                 $urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 4));
        run_random(400, 1, -1);
        drain();

        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && result_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
